// File: rtl/core/ttok_pkg.sv
// Shared types, constants and byte classes for the text tokenizer stream core.
// No dependencies; every other file of the core refers to this package by scoped names.
package ttok_pkg;

   localparam int MaxResults = 4;
   localparam int CountWidth = $clog2(MaxResults + 1);
   localparam int IndexWidth = $clog2(MaxResults);

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LETTER_S  = 8'h73;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_DOT       = 8'h2E;

   localparam logic CMD_TEXT = 1'b0;
   localparam logic CMD_EOT  = 1'b1;

   localparam logic EMIT_SPACES_RESET = 1'b1;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_ALPHA = 3'd1,
      MODE_INT   = 3'd2,
      MODE_IDOT  = 3'd3,
      MODE_FRAC  = 3'd4
   } lex_mode_type;

   typedef struct packed {
      logic       command;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      logic [7:0] token_char;
      logic       token_end;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [CountWidth-1:0]     count;
      rsp_type [MaxResults-1:0]  items;
   } batch_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
   endfunction

   function automatic logic is_separator(input logic [7:0] b);
      return (b == CHAR_COMMA) || (b == CHAR_DOT);
   endfunction

endpackage

// File: rtl/core/text_tokenizer_stream_core.sv
// Top level of the streaming text tokenizer: control register, lexer and result bank.
// Depends on ttok_pkg, ttok_lexer and ttok_rsp_queue.
//
// One text byte (or end-of-text) is accepted per transaction and turned combinationally
// into a batch of zero to four token characters, which leave on the result port one per
// cycle while rsp_stall is low. A new transaction is taken whenever the result bank is
// empty or is handing out its final entry with rsp_stall low. Whitespace with emit_spaces
// set gives two results; closing an open token adds its held character, and a pending
// separator one more, so a single item gives four results at most.
// csr_data writes emit_spaces (reset 1); csr_ready is always high.
module text_tokenizer_stream_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ttok_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ttok_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);

   logic emit_spaces_ff;
   logic load_ok;
   logic accept;
   ttok_pkg::batch_type batch;

   assign csr_ready = 1'b1;
   assign req_stall = !load_ok;
   assign accept    = req_valid && load_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_spaces_ff <= ttok_pkg::EMIT_SPACES_RESET;
      end else if (csr_valid && csr_ready) begin
         emit_spaces_ff <= csr_data;
      end
   end

   ttok_lexer u_lexer (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .emit_spaces (emit_spaces_ff),
      .req         (req_data),
      .batch       (batch)
   );

   ttok_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .batch     (batch),
      .load_ok   (load_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/core/ttok_lexer.sv
// Lexer state registers and the single-pass next-state / result batch logic.
// Depends on ttok_pkg.
module ttok_lexer (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               emit_spaces,
   input  ttok_pkg::req_type  req,
   output ttok_pkg::batch_type batch
);

   ttok_pkg::lex_mode_type mode_ff, mode_in;
   logic [7:0] held_ff, held_in;
   logic [7:0] sep_ff, sep_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ttok_pkg::MODE_IDLE;
         held_ff <= 8'd0;
         sep_ff  <= 8'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
         sep_ff  <= sep_in;
      end
   end

   always_comb begin
      logic [7:0] b;
      logic       close;
      logic       start;
      logic [ttok_pkg::CountWidth-1:0] n;
      logic [ttok_pkg::CountWidth-1:0] lastn;
      b       = req.char_in;
      close   = 1'b0;
      start   = 1'b0;
      n       = '0;
      lastn   = '0;
      mode_in = mode_ff;
      held_in = held_ff;
      sep_in  = sep_ff;
      batch   = '0;

      if (req.command == ttok_pkg::CMD_EOT) begin
         close = 1'b1;
      end else begin
         case (mode_ff)
            ttok_pkg::MODE_ALPHA: begin
               if (ttok_pkg::is_alpha(b)) begin
                  batch.items[n[ttok_pkg::IndexWidth-1:0]] = '{held_ff, 1'b0, 1'b0};
                  n = n + 1'b1;
                  held_in = b;
               end else begin
                  close = 1'b1;
                  start = 1'b1;
               end
            end
            ttok_pkg::MODE_INT: begin
               if (ttok_pkg::is_separator(b)) begin
                  sep_in  = b;
                  mode_in = ttok_pkg::MODE_IDOT;
               end else if (ttok_pkg::is_digit(b)) begin
                  batch.items[n[ttok_pkg::IndexWidth-1:0]] = '{held_ff, 1'b0, 1'b0};
                  n = n + 1'b1;
                  held_in = b;
               end else begin
                  close = 1'b1;
                  start = 1'b1;
               end
            end
            ttok_pkg::MODE_IDOT: begin
               if (ttok_pkg::is_digit(b)) begin
                  batch.items[n[ttok_pkg::IndexWidth-1:0]] = '{held_ff, 1'b0, 1'b0};
                  n = n + 1'b1;
                  batch.items[n[ttok_pkg::IndexWidth-1:0]] = '{sep_ff, 1'b0, 1'b0};
                  n = n + 1'b1;
                  held_in = b;
                  mode_in = ttok_pkg::MODE_FRAC;
               end else begin
                  close = 1'b1;
                  start = 1'b1;
               end
            end
            ttok_pkg::MODE_FRAC: begin
               if (ttok_pkg::is_digit(b)) begin
                  batch.items[n[ttok_pkg::IndexWidth-1:0]] = '{held_ff, 1'b0, 1'b0};
                  n = n + 1'b1;
                  held_in = b;
               end else begin
                  close = 1'b1;
                  start = 1'b1;
               end
            end
            default: begin
               start = 1'b1;
            end
         endcase
      end

      if (close) begin
         case (mode_ff)
            ttok_pkg::MODE_ALPHA, ttok_pkg::MODE_INT, ttok_pkg::MODE_FRAC: begin
               batch.items[n[ttok_pkg::IndexWidth-1:0]] = '{held_ff, 1'b1, 1'b0};
               n = n + 1'b1;
            end
            ttok_pkg::MODE_IDOT: begin
               batch.items[n[ttok_pkg::IndexWidth-1:0]] = '{held_ff, 1'b1, 1'b0};
               n = n + 1'b1;
               batch.items[n[ttok_pkg::IndexWidth-1:0]] = '{sep_ff, 1'b1, 1'b0};
               n = n + 1'b1;
            end
            default: begin
            end
         endcase
         mode_in = ttok_pkg::MODE_IDLE;
      end

      if (start) begin
         mode_in = ttok_pkg::MODE_IDLE;
         if (ttok_pkg::is_digit(b)) begin
            held_in = b;
            mode_in = ttok_pkg::MODE_INT;
         end else if (ttok_pkg::is_alpha(b)) begin
            held_in = b;
            mode_in = ttok_pkg::MODE_ALPHA;
         end else if (ttok_pkg::is_space(b)) begin
            if (emit_spaces) begin
               batch.items[n[ttok_pkg::IndexWidth-1:0]] =
                  '{ttok_pkg::CHAR_BACKSLASH, 1'b0, 1'b0};
               n = n + 1'b1;
               batch.items[n[ttok_pkg::IndexWidth-1:0]] =
                  '{ttok_pkg::CHAR_LETTER_S, 1'b1, 1'b0};
               n = n + 1'b1;
            end
         end else begin
            batch.items[n[ttok_pkg::IndexWidth-1:0]] = '{b, 1'b1, 1'b0};
            n = n + 1'b1;
         end
      end

      if (n != '0) begin
         lastn = n - 1'b1;
         batch.items[lastn[ttok_pkg::IndexWidth-1:0]].last = 1'b1;
      end
      batch.count = n;
   end

endmodule

// File: rtl/core/ttok_rsp_queue.sv
// Result register bank: holds one item's batch of results and drains it one per cycle while rsp_stall is low.
// Depends on ttok_pkg.
module ttok_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  ttok_pkg::batch_type batch,
   output logic                load_ok,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ttok_pkg::rsp_type   rsp_data
);

   ttok_pkg::rsp_type [ttok_pkg::MaxResults-1:0] items_ff;
   logic [ttok_pkg::CountWidth-1:0] left_ff, left_in;
   logic [ttok_pkg::IndexWidth-1:0] rd_ff, rd_in;
   logic take;

   assign rsp_valid = (left_ff != '0);
   assign rsp_data  = items_ff[rd_ff];
   assign take      = rsp_valid && !rsp_stall;
   assign load_ok   = (left_ff == '0) ||
                      ((left_ff == ttok_pkg::CountWidth'(1)) && !rsp_stall);

   always_comb begin
      left_in = left_ff;
      rd_in   = rd_ff;
      if (load) begin
         left_in = batch.count;
         rd_in   = '0;
      end else if (take) begin
         left_in = left_ff - 1'b1;
         rd_in   = rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         rd_ff   <= '0;
      end else begin
         left_ff <= left_in;
         rd_ff   <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         items_ff <= batch.items;
      end
   end

endmodule

// File: dv/text_tokenizer_stream_core_checker.sv
// Transaction checker for the text tokenizer stream core: watches the request, result and
// register channels, predicts the token characters and compares them. Depends on ttok_pkg.
module text_tokenizer_stream_core_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  ttok_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  ttok_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic              csr_data,
   output int                fail_count,
   output int                outstanding,
   output int                items_seen,
   output int                results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CHAR_0       = 8'h30;
   localparam logic [7:0] CHAR_9       = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   ttok_pkg::lex_mode_type scan_mode;
   logic [7:0]             held_byte;
   logic [7:0]             sep_byte;
   logic                   emit_blanks;

   ttok_pkg::rsp_type expected_tokens[$];
   ttok_pkg::rsp_type item_tokens[$];
   ttok_pkg::rsp_type want;
   int                errors;
   int                n_items;
   int                n_results;

   function automatic logic digit_byte(input logic [7:0] b);
      return b >= CHAR_0 && b <= CHAR_9;
   endfunction

   function automatic logic letter_byte(input logic [7:0] b);
      return (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
             (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z);
   endfunction

   function automatic logic blank_byte(input logic [7:0] b);
      return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
   endfunction

   function automatic logic sep_char(input logic [7:0] b);
      return b == ttok_pkg::CHAR_COMMA || b == ttok_pkg::CHAR_DOT;
   endfunction

   function void emit_char(input logic [7:0] c, input logic end_mark);
      ttok_pkg::rsp_type t;
      t.token_char = c;
      t.token_end  = end_mark;
      t.last       = 1'b0;
      if (item_tokens.size() < ttok_pkg::MaxResults)
         item_tokens = {item_tokens, t};
   endfunction

   function void close_open_token();
      case (scan_mode)
         ttok_pkg::MODE_ALPHA, ttok_pkg::MODE_INT, ttok_pkg::MODE_FRAC: begin
            emit_char(held_byte, 1'b1);
         end
         ttok_pkg::MODE_IDOT: begin
            emit_char(held_byte, 1'b1);
            emit_char(sep_byte, 1'b1);
         end
         default: ;
      endcase
      scan_mode = ttok_pkg::MODE_IDLE;
   endfunction

   function void open_token(input logic [7:0] b);
      if (digit_byte(b)) begin
         held_byte = b;
         scan_mode = ttok_pkg::MODE_INT;
      end else if (letter_byte(b)) begin
         held_byte = b;
         scan_mode = ttok_pkg::MODE_ALPHA;
      end else if (blank_byte(b)) begin
         if (emit_blanks) begin
            emit_char(ttok_pkg::CHAR_BACKSLASH, 1'b0);
            emit_char(ttok_pkg::CHAR_LETTER_S, 1'b1);
         end
      end else begin
         emit_char(b, 1'b1);
      end
   endfunction

   function void predict_tokens(input ttok_pkg::req_type r);
      logic [7:0] b;
      b = r.char_in;
      item_tokens.delete();
      if (r.command == ttok_pkg::CMD_EOT) begin
         close_open_token();
      end else begin
         case (scan_mode)
            ttok_pkg::MODE_ALPHA: begin
               if (letter_byte(b)) begin
                  emit_char(held_byte, 1'b0);
                  held_byte = b;
               end else begin
                  close_open_token();
                  open_token(b);
               end
            end
            ttok_pkg::MODE_INT: begin
               if (sep_char(b)) begin
                  sep_byte  = b;
                  scan_mode = ttok_pkg::MODE_IDOT;
               end else if (digit_byte(b)) begin
                  emit_char(held_byte, 1'b0);
                  held_byte = b;
               end else begin
                  close_open_token();
                  open_token(b);
               end
            end
            ttok_pkg::MODE_IDOT: begin
               if (digit_byte(b)) begin
                  emit_char(held_byte, 1'b0);
                  emit_char(sep_byte, 1'b0);
                  held_byte = b;
                  scan_mode = ttok_pkg::MODE_FRAC;
               end else begin
                  close_open_token();
                  open_token(b);
               end
            end
            ttok_pkg::MODE_FRAC: begin
               if (digit_byte(b)) begin
                  emit_char(held_byte, 1'b0);
                  held_byte = b;
               end else begin
                  close_open_token();
                  open_token(b);
               end
            end
            default: begin
               scan_mode = ttok_pkg::MODE_IDLE;
               open_token(b);
            end
         endcase
      end
      if (item_tokens.size() > 0)
         item_tokens[item_tokens.size() - 1].last = 1'b1;
      expected_tokens = {expected_tokens, item_tokens};
   endfunction

   initial begin
      errors    = 0;
      n_items   = 0;
      n_results = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         scan_mode   = ttok_pkg::MODE_IDLE;
         held_byte   = '0;
         sep_byte    = '0;
         emit_blanks = ttok_pkg::EMIT_SPACES_RESET;
         expected_tokens.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (expected_tokens.size() == 0) begin
               errors++;
               $display("%0t: unexpected token transaction, expected none,", $time,
                        " got char %02h end %0b last %0b",
                        rsp_data.token_char, rsp_data.token_end, rsp_data.last);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_data.token_char !== want.token_char ||
                   rsp_data.token_end !== want.token_end ||
                   rsp_data.last !== want.last) begin
                  errors++;
                  $display("%0t: token mismatch, expected char %02h end %0b last %0b,",
                           $time, want.token_char, want.token_end, want.last,
                           " got char %02h end %0b last %0b",
                           rsp_data.token_char, rsp_data.token_end, rsp_data.last);
               end
            end
         end
         if (req_valid && !req_stall) begin
            n_items++;
            predict_tokens(req_data);
         end
         if (csr_valid && csr_ready)
            emit_blanks = csr_data;
      end
      fail_count   <= errors;
      outstanding  <= expected_tokens.size();
      items_seen   <= n_items;
      results_seen <= n_results;
   end

endmodule

// File: dv/text_tokenizer_stream_core_tb.sv
// Testbench top for the text tokenizer stream core: clock, reset, text stimulus, register
// writes, receiver back-pressure and the verdict. Depends on ttok_pkg, the core and the checker.
module text_tokenizer_stream_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CHAR_0       = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   ttok_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   ttok_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_data;

   int   fail_count;
   int   outstanding;
   int   items_seen;
   int   results_seen;
   int   items_sent;
   int   csr_writes;
   logic idle_on;
   logic pressure_req;

   text_tokenizer_stream_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   text_tokenizer_stream_core_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .outstanding  (outstanding),
      .items_seen   (items_seen),
      .results_seen (results_seen)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [7:0] rand_letter();
      if ($urandom_range(0, 1))
         return CHAR_UPPER_A + 8'($urandom_range(0, 25));
      return CHAR_LOWER_A + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_blank();
      if ($urandom_range(0, 1))
         return CHAR_SPACE;
      return CHAR_TAB + 8'($urandom_range(0, 4));
   endfunction

   function automatic logic [7:0] rand_sep();
      return $urandom_range(0, 1) ? ttok_pkg::CHAR_COMMA : ttok_pkg::CHAR_DOT;
   endfunction

   task automatic send_item(input ttok_pkg::req_type r);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text(input logic [7:0] b);
      ttok_pkg::req_type r;
      r.command = ttok_pkg::CMD_TEXT;
      r.char_in = b;
      send_item(r);
   endtask

   task automatic send_eot();
      ttok_pkg::req_type r;
      r.command = ttok_pkg::CMD_EOT;
      r.char_in = 8'($urandom_range(0, 255));
      send_item(r);
   endtask

   task automatic send_digits(input int n);
      repeat (n) send_text(CHAR_0 + 8'($urandom_range(0, 9)));
   endtask

   // one word, number, decimal, blank, end-of-text, separator or stray byte of random text
   task automatic send_phrase();
      int         kind;
      logic [7:0] b;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1: begin
            repeat ($urandom_range(1, 6)) send_text(rand_letter());
            if ($urandom_range(0, 1)) send_text(rand_blank());
         end
         2, 3: begin
            send_digits($urandom_range(1, 5));
            if ($urandom_range(0, 1)) send_text(rand_blank());
         end
         4: begin
            send_digits($urandom_range(1, 4));
            send_text(rand_sep());
            send_digits($urandom_range(1, 4));
         end
         5: begin
            send_digits($urandom_range(1, 3));
            send_text(rand_sep());
            if ($urandom_range(0, 3) == 0) begin
               send_eot();
            end else begin
               do b = 8'($urandom_range(0, 255)); while (b >= CHAR_0 && b <= CHAR_0 + 9);
               send_text(b);
            end
         end
         6: send_text(rand_blank());
         7: send_eot();
         8: send_text(8'($urandom_range(0, 255)));
         default: send_text(rand_sep());
      endcase
   endtask

   task automatic send_random(input int n);
      int stop_at;
      stop_at = items_sent + n;
      while (items_sent < stop_at) send_phrase();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_emit_spaces(input logic v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   initial begin
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_req) begin
            pressure_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 8);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_data     = 1'b0;
      idle_on      = 1'b1;
      pressure_req = 1'b0;
      items_sent   = 0;
      csr_writes   = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed text, spaces emitted from reset
      send_eot();
      send_text("A");
      send_text("z");
      send_text("0");
      send_text("9");
      send_text(ttok_pkg::CHAR_DOT);
      send_text("5");
      send_text(CHAR_SPACE);
      send_text("1");
      send_text(ttok_pkg::CHAR_COMMA);
      send_eot();
      send_eot();
      send_text("7");
      send_text(ttok_pkg::CHAR_DOT);
      send_text(CHAR_SPACE);
      send_text(8'h00);
      send_text(8'hFF);
      send_text(8'h80);
      send_text("3");
      send_text(ttok_pkg::CHAR_COMMA);
      send_text(ttok_pkg::CHAR_COMMA);
      send_text("Z");
      send_text(CHAR_TAB);
      send_eot();
      drain();

      write_emit_spaces(1'b0);
      send_text(CHAR_SPACE);
      send_text("8");
      send_text(8'h0D);
      send_random(150);
      drain();

      write_emit_spaces(1'b1);
      pressure_req = 1'b1;
      send_random(150);
      drain();

      write_emit_spaces(1'b0);
      send_random(100);
      drain();

      idle_on = 1'b0;
      write_emit_spaces(1'b1);
      send_random(100);
      drain();
      repeat (8) @(posedge clock);

      $display("Summary: %0d text/end-of-text transactions in, %0d token characters checked,",
               items_seen, results_seen);
      $display("         %0d emit_spaces writes, both settings, one long receiver hold-off",
               csr_writes);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
